// ===== rtl/msl_pkg.sv =====
`timescale 1ns / 1ps
package msl_pkg;

    localparam int LIST_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    // walk length and list total need one bit more than a single count
    localparam int TOT_W      = CNT_W + 1;
    localparam int VAL_W      = 32;
    localparam int MED_W      = VAL_W + 1;

    localparam logic CMD_FIRST  = 1'b0;
    localparam logic CMD_SECOND = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic signed [VAL_W-1:0] value;
        logic                    end_of_load;
    } t_in;

    typedef struct packed {
        logic signed [MED_W-1:0] median_doubled;
        logic                    overflow;
    } t_out;

    typedef enum logic [1:0] {
        S_LOAD,
        S_PRIME,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic emit;
    } t_ctl;

    typedef struct packed {
        logic walk_done;
        logic out_busy;
    } t_sts;

endpackage

// ===== rtl/msl_ctrl.sv =====
`timescale 1ns / 1ps
module msl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_end_of_load,
    input  logic          i_out_ready,
    input  msl_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output msl_pkg::t_ctl o_ctl
);
    import msl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_ctl      = '0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    if (i_end_of_load) begin
                        n_state = S_PRIME;
                    end
                end
            end
            S_PRIME: begin
                // index 0 of both lists is fetched here
                o_ctl.start = 1'b1;
                n_state     = S_WALK;
            end
            S_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.step = 1'b1;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy || i_out_ready) begin
                    o_ctl.emit = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

endmodule

// ===== rtl/msl_dp.sv =====
`timescale 1ns / 1ps
module msl_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  msl_pkg::t_ctl i_ctl,
    input  msl_pkg::t_in  i_in_data,
    input  logic          i_out_ready,
    output msl_pkg::t_sts o_sts,
    output logic          o_out_valid,
    output msl_pkg::t_out o_out_data
);
    import msl_pkg::*;

    logic signed [VAL_W-1:0] r_mem1 [LIST_DEPTH];
    logic signed [VAL_W-1:0] r_mem2 [LIST_DEPTH];
    logic signed [VAL_W-1:0] r_rd1;
    logic signed [VAL_W-1:0] r_rd2;

    logic [CNT_W-1:0] r_n1, r_n2;
    logic [CNT_W-1:0] r_i, r_j;
    logic [CNT_W-1:0] n_i, n_j;
    logic [TOT_W-1:0] r_k;
    logic             r_drop;
    logic signed [VAL_W-1:0] r_last, r_prev;
    logic             r_out_valid;
    t_out             r_out;

    logic             full1, full2;
    logic [TOT_W-1:0] total;
    logic [TOT_W-1:0] target;
    logic             take_first;
    logic signed [VAL_W-1:0] pick;
    logic signed [MED_W-1:0] med;

    assign full1  = (r_n1 == CNT_W'(LIST_DEPTH));
    assign full2  = (r_n2 == CNT_W'(LIST_DEPTH));
    assign total  = TOT_W'(r_n1) + TOT_W'(r_n2);
    assign target = (total >> 1) + TOT_W'(1);

    // first list wins on ties
    assign take_first = (r_i < r_n1) && ((r_j >= r_n2) || (r_rd1 <= r_rd2));
    assign pick       = take_first ? r_rd1 : r_rd2;

    always_comb begin
        n_i = r_i;
        n_j = r_j;
        if (i_ctl.start) begin
            n_i = '0;
            n_j = '0;
        end else if (i_ctl.step) begin
            if (take_first) begin
                n_i = r_i + CNT_W'(1);
            end else begin
                n_j = r_j + CNT_W'(1);
            end
        end
    end

    // memory ports: one write for loading, one read fed by the next walk index
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_in_data.cmd == CMD_FIRST && !full1) begin
            r_mem1[r_n1[ADDR_W-1:0]] <= i_in_data.value;
        end
        r_rd1 <= r_mem1[n_i[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_in_data.cmd == CMD_SECOND && !full2) begin
            r_mem2[r_n2[ADDR_W-1:0]] <= i_in_data.value;
        end
        r_rd2 <= r_mem2[n_j[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_j <= n_j;
        if (i_ctl.start) begin
            r_k    <= '0;
            r_last <= '0;
            r_prev <= '0;
        end else if (i_ctl.step) begin
            r_k    <= r_k + TOT_W'(1);
            r_prev <= r_last;
            r_last <= pick;
        end
    end

    always_comb begin
        if (total[0]) begin
            med = {r_last, 1'b0};
        end else begin
            med = MED_W'(r_last) + MED_W'(r_prev);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n1        <= '0;
            r_n2        <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.emit) begin
                r_n1        <= '0;
                r_n2        <= '0;
                r_drop      <= 1'b0;
                r_out_valid <= 1'b1;
            end else begin
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
                if (i_ctl.load) begin
                    if (i_in_data.cmd == CMD_FIRST) begin
                        if (full1) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_n1 <= r_n1 + CNT_W'(1);
                        end
                    end else begin
                        if (full2) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_n2 <= r_n2 + CNT_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out.median_doubled <= med;
            r_out.overflow       <= r_drop;
        end
    end

    assign o_sts.walk_done = (r_k == target);
    assign o_sts.out_busy  = r_out_valid;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

// ===== rtl/median_of_two_sorted_lists.sv =====
`timescale 1ns / 1ps
// Median of two sorted lists, reported doubled (one fractional bit).
// Input channel (i_in_valid / o_in_ready / i_in_data): each beat appends
// one signed element to the list named by cmd; a full list drops the beat
// and marks overflow. One element is taken every cycle while loading.
// The beat with end_of_load set is stored like any other and then starts a
// merge walk over both lists, one element per cycle through the read ports
// of the two list memories. The walk stops after total/2 + 1 elements
// (total = elements held in both lists); the result beat is then loaded
// into the output register, and no input is taken until then. Afterwards
// both lists and the overflow mark are empty and loading resumes.
// Output channel (o_out_valid / i_out_ready / o_out_data): the result sits
// in an output register; loading of the next set goes on while it waits.
// If the receiver still holds off when the next result is ready, the block
// waits with o_in_ready low until the register is free.
// Reset (i_rst_n low, synchronous) empties both lists, clears the overflow
// mark and drops any pending result. List memories need no clearing pass.
module median_of_two_sorted_lists (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  msl_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output msl_pkg::t_out o_out_data
);
    import msl_pkg::*;

    t_ctl ctl;
    t_sts sts;

    msl_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_end_of_load (i_in_data.end_of_load),
        .i_out_ready   (i_out_ready),
        .i_sts         (sts),
        .o_in_ready    (o_in_ready),
        .o_ctl         (ctl)
    );

    msl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/msl_chk.sv =====
`timescale 1ns / 1ps
module msl_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input msl_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input msl_pkg::t_out o_out_data
);
    import msl_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed under stall");

    // final beat keeps the input closed through the prime state and into the walk
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.end_of_load |=>
            !o_in_ready ##1 !o_in_ready)
        else $error("input reopened during walk");

    // a fresh result only comes out of the walk
    a_result_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared while loading");

endmodule

bind median_of_two_sorted_lists msl_chk u_msl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import msl_pkg::*;

    localparam int STY_WIDE     = 0;
    localparam int STY_TIES     = 1;
    localparam int STY_EDGE     = 2;
    localparam int STY_SCRAMBLE = 3;

    localparam int ORD_MIX      = 0;
    localparam int ORD_A_FIRST  = 1;
    localparam int ORD_B_FIRST  = 2;

    localparam int STIM_ITEMS   = 1700;
    localparam int QUIET_ITEMS  = 250;
    localparam int HOLD_AT      = 100;
    localparam int HOLD_LEN     = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int DRAIN_LIMIT  = 20000;

    typedef struct {
        t_in data;
        bit  pause;
    } t_item;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    median_of_two_sorted_lists dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // predictor state
    logic signed [VAL_W-1:0] first_mem  [LIST_DEPTH];
    logic signed [VAL_W-1:0] second_mem [LIST_DEPTH];
    int   first_n  = 0;
    int   second_n = 0;
    bit   lost     = 1'b0;
    t_out median_q [$];

    t_item pending [$];
    int    n_items   = 0;
    int    beats_in  = 0;
    int    errs      = 0;
    int    tx_gap    = 0;
    int    rx_gap    = 0;
    int    hold_left = 0;
    bit    hold_done = 1'b0;
    bit    quiet     = 1'b0;

    function automatic logic signed [MED_W-1:0] merged_median();
        int     total, target, i, j, k;
        longint last, prev, med;
        total  = first_n + second_n;
        target = total / 2 + 1;
        i = 0;
        j = 0;
        last = 0;
        prev = 0;
        // first list wins ties
        for (k = 0; k < target; k++) begin
            prev = last;
            if (i < first_n && (j >= second_n || first_mem[i] <= second_mem[j])) begin
                last = first_mem[i];
                i++;
            end else begin
                last = second_mem[j];
                j++;
            end
        end
        med = (total % 2 != 0) ? 2 * last : last + prev;
        return med[MED_W-1:0];
    endfunction

    task automatic take_beat(input t_in b);
        t_out r;
        if (b.cmd == CMD_FIRST) begin
            if (first_n < LIST_DEPTH) begin
                first_mem[first_n] = b.value;
                first_n++;
            end else begin
                lost = 1'b1;
            end
        end else begin
            if (second_n < LIST_DEPTH) begin
                second_mem[second_n] = b.value;
                second_n++;
            end else begin
                lost = 1'b1;
            end
        end
        if (b.end_of_load) begin
            r.median_doubled = merged_median();
            r.overflow       = lost;
            median_q.insert(median_q.size(), r);
            first_n  = 0;
            second_n = 0;
            lost     = 1'b0;
        end
    endtask

    task automatic add_beat(input logic cmd, input logic signed [VAL_W-1:0] v, input bit eol);
        t_item it;
        it.data.cmd         = cmd;
        it.data.value       = v;
        it.data.end_of_load = eol;
        it.pause            = 1'b0;
        pending.insert(pending.size(), it);
        n_items++;
    endtask

    task automatic add_pause();
        t_item it;
        it.data  = '0;
        it.pause = 1'b1;
        pending.insert(pending.size(), it);
    endtask

    task automatic fill_list(ref logic signed [VAL_W-1:0] q[$], input int n, input int style);
        longint          cur, span;
        longint unsigned r;
        int              k;
        q.delete();
        case (style)
            STY_WIDE: begin
                cur  = longint'($signed($urandom));
                span = (64'sd2147483647 - cur) / (n + 1);
            end
            STY_TIES: cur = longint'($urandom_range(0, 200)) - 100;
            STY_EDGE: begin
                if ($urandom_range(0, 1) != 0)
                    cur = -64'sd2147483648 + $urandom_range(0, 2);
                else
                    cur = 64'sd2147483647 - $urandom_range(0, 4);
            end
            default: cur = 0;
        endcase
        for (k = 0; k < n; k++) begin
            case (style)
                STY_WIDE: begin
                    r   = {$urandom, $urandom};
                    cur = cur + longint'(r % longint'(2 * span + 1));
                end
                STY_TIES: cur = cur + $urandom_range(0, 2);
                STY_EDGE: cur = cur + $urandom_range(0, 1);
                default:  cur = longint'($signed($urandom));
            endcase
            if (cur > 64'sd2147483647)
                cur = 64'sd2147483647;
            q.insert(q.size(), cur[VAL_W-1:0]);
        end
    endtask

    task automatic gen_set(input int na, input int nb, input int style, input int order);
        logic signed [VAL_W-1:0] qa [$];
        logic signed [VAL_W-1:0] qb [$];
        int ia, ib, tot, k;
        bit pick_a;
        fill_list(qa, na, style);
        fill_list(qb, nb, style);
        tot = na + nb;
        ia  = 0;
        ib  = 0;
        for (k = 0; k < tot; k++) begin
            case (order)
                ORD_A_FIRST: pick_a = (ia < na);
                ORD_B_FIRST: pick_a = (ib >= nb);
                default:     pick_a = (ib >= nb) ? 1'b1 :
                                      (ia >= na) ? 1'b0 : bit'($urandom_range(0, 1));
            endcase
            if (pick_a) begin
                add_beat(CMD_FIRST, qa[ia], k == tot - 1);
                ia++;
            end else begin
                add_beat(CMD_SECOND, qb[ib], k == tot - 1);
                ib++;
            end
        end
    endtask

    // driver: takes beats from the pending queue, predicts at acceptance
    always @(posedge i_clk) begin : drv
        t_item nx;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready === 1'b1) begin
                take_beat(i_in_data);
                beats_in <= beats_in + 1;
            end
            if (!i_in_valid || o_in_ready === 1'b1) begin
                if (tx_gap != 0) begin
                    tx_gap     <= tx_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (pending[0].pause) begin
                    // hold back until every result is out
                    if (median_q.size() == 0)
                        void'(pending.pop_front());
                    i_in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    tx_gap     <= $urandom_range(0, 3);
                    i_in_valid <= 1'b0;
                end else begin
                    nx = pending.pop_front();
                    i_in_data  <= nx.data;
                    i_in_valid <= 1'b1;
                end
            end
            quiet <= (pending.size() < QUIET_ITEMS);
        end
    end

    // long receiver hold-off so the block backs up onto its input
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && beats_in >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // monitor: checks each result beat against the oldest prediction
    always @(posedge i_clk) begin : mon
        t_out w;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (median_q.size() == 0) begin
                $error("unexpected result beat: median_doubled %0d overflow %0b",
                       o_out_data.median_doubled, o_out_data.overflow);
                errs++;
            end else begin
                w = median_q.pop_front();
                if (o_out_data.median_doubled !== w.median_doubled) begin
                    $error("median_doubled expected %0d actual %0d",
                           w.median_doubled, o_out_data.median_doubled);
                    errs++;
                end
                if (o_out_data.overflow !== w.overflow) begin
                    $error("overflow expected %0b actual %0b",
                           w.overflow, o_out_data.overflow);
                    errs++;
                end
            end
        end
        if (!i_rst_n || hold_left != 0) begin
            i_out_ready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap      <= rx_gap - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rx_gap      <= $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        #(4_000_000);
        $display("status: fail");
        $finish;
    end

    initial begin : stim
        int sets, na, nb, sty, k;

        // directed: extremes, ties, one-sided lists, odd and even totals
        add_beat(CMD_FIRST,  32'sh7fffffff, 1'b1);
        add_beat(CMD_SECOND, 32'sh80000000, 1'b1);
        add_beat(CMD_FIRST,  32'sh7fffffff, 1'b0);
        add_beat(CMD_SECOND, 32'sh7fffffff, 1'b1);
        add_beat(CMD_SECOND, 32'sh80000000, 1'b0);
        add_beat(CMD_FIRST,  32'sh80000000, 1'b1);
        add_beat(CMD_FIRST,  32'sd5, 1'b0);
        add_beat(CMD_SECOND, 32'sd5, 1'b0);
        add_beat(CMD_FIRST,  32'sd5, 1'b1);
        add_beat(CMD_FIRST,  -32'sd3, 1'b0);
        add_beat(CMD_SECOND, 32'sd2, 1'b0);
        add_beat(CMD_FIRST,  32'sd1, 1'b0);
        add_beat(CMD_SECOND, 32'sd4, 1'b0);
        add_beat(CMD_FIRST,  32'sd7, 1'b1);
        for (k = 1; k <= 4; k++)
            add_beat(CMD_SECOND, k, k == 4);
        add_beat(CMD_SECOND, -32'sd5, 1'b0);
        add_beat(CMD_FIRST,  32'sd10, 1'b0);
        add_beat(CMD_SECOND, 32'sd0, 1'b0);
        add_beat(CMD_FIRST,  32'sd20, 1'b0);
        add_beat(CMD_SECOND, 32'sd30, 1'b1);
        // unsorted first list
        add_beat(CMD_FIRST,  32'sd9, 1'b0);
        add_beat(CMD_FIRST,  32'sd1, 1'b0);
        add_beat(CMD_SECOND, 32'sd3, 1'b1);
        add_pause();

        sets = 0;
        while (n_items < STIM_ITEMS) begin
            if (sets == 60) begin
                // first list overflows, final beat dropped too
                gen_set(LIST_DEPTH + 2, $urandom_range(0, 3), STY_WIDE, ORD_B_FIRST);
                add_pause();
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    na = $urandom_range(0, 40);
                    nb = $urandom_range(0, 40);
                end else begin
                    na = $urandom_range(0, 6);
                    nb = $urandom_range(0, 6);
                end
                if (na + nb == 0)
                    na = 1;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: sty = STY_WIDE;
                    4, 5, 6:    sty = STY_TIES;
                    7, 8:       sty = STY_EDGE;
                    default:    sty = STY_SCRAMBLE;
                endcase
                gen_set(na, nb, sty, (sets % 5 == 0) ? ORD_A_FIRST : ORD_MIX);
            end
            if ($urandom_range(0, 29) == 0)
                add_pause();
            sets++;
        end

        @(posedge i_clk);
        while (!i_rst_n || pending.size() != 0 || i_in_valid)
            @(posedge i_clk);
        k = 0;
        while (median_q.size() != 0 && k < DRAIN_LIMIT) begin
            @(posedge i_clk);
            k++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (median_q.size() != 0) begin
            $error("%0d predicted results never arrived", median_q.size());
            errs++;
        end
        if (errs == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

endmodule

// ===== files.f =====
rtl/msl_pkg.sv
rtl/msl_ctrl.sv
rtl/msl_dp.sv
rtl/median_of_two_sorted_lists.sv
rtl/msl_chk.sv
sim/tb_top.sv
